// ===== sv/afde_pkg.sv =====
// Shared types and codes of the ASCII frame delta encoder.
package afde_pkg;

  localparam int unsigned REG_WIDTH  = 0;
  localparam int unsigned REG_HEIGHT = 1;
  localparam int unsigned REG_LEVELS = 2;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_END,
    EMIT_IFR,
    EMIT_PFR
  } emit_e;

  typedef struct packed {
    logic  cap;
    logic  commit;
    logic  rd_drain;
    logic  div_start;
    logic  pos_inc;
    logic  emit;
    emit_e emit_kind;
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic iframe;
    logic cnt_zero;
    logic scan_end;
    logic map_hit;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/afde_dp.sv =====
// Datapath: index arithmetic, frame and change stores, counters, divider and result register.
module afde_dp #(
  parameter int MAX_PIXELS = 16384,
  parameter int MAX_DIM    = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  afde_pkg::cmd_t cmd_i,
  output afde_pkg::stat_t stat_o,
  input  logic [7:0]     width_i,
  input  logic [7:0]     height_i,
  input  logic [8:0]     levels_i,
  input  logic [7:0]     red_i,
  input  logic [7:0]     green_i,
  input  logic [7:0]     blue_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [7:0]     out_idx_o,
  output logic [6:0]     out_x_o,
  output logic [6:0]     out_y_o,
  output logic           out_iframe_o,
  output logic           out_last_o,
  output logic           out_empty_o
);
  import afde_pkg::*;

  localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int AW = $clog2(2 * MAX_PIXELS);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int KW = $clog2(PW + 1);

  int w_int, h_int, pix_int;
  logic [DW-1:0] w_eff;
  logic [CW-1:0] pixels;
  logic [7:0]    lvm1;

  always_comb begin
    w_int = (width_i == 8'd0) ? 1 : ((int'(width_i) > MAX_DIM) ? MAX_DIM : int'(width_i));
    h_int = (height_i == 8'd0) ? 1 : ((int'(height_i) > MAX_DIM) ? MAX_DIM : int'(height_i));
    pix_int = w_int * h_int;
    if (pix_int > MAX_PIXELS) begin
      pix_int = MAX_PIXELS;
    end
    w_eff  = DW'(w_int);
    pixels = CW'(pix_int);
    if (levels_i == 9'd0) begin
      lvm1 = 8'd0;
    end else if (levels_i > 9'd256) begin
      lvm1 = 8'd255;
    end else begin
      lvm1 = 8'(levels_i - 9'd1);
    end
  end

  logic [7:0]  red_q, green_q, blue_q;
  logic [7:0]  luma_q, q0_q, idx_q, idx_d;
  logic [15:0] t_q, t2_q;
  logic [16:0] rem17;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    luma_q <= 8'((24'(red_q) * 24'd13933 + 24'(green_q) * 24'd46871
                  + 24'(blue_q) * 24'd4732) >> 16);
    t_q    <= 16'(16'(luma_q) * 16'(lvm1) + 16'd127);
    q0_q   <= 8'((24'(t_q) * 24'd257) >> 16);
    t2_q   <= t_q;
    idx_q  <= idx_d;
  end

  always_comb begin
    rem17 = 17'(t2_q) - 17'(17'(q0_q) * 17'd255);
    idx_d = (rem17 >= 17'd255) ? q0_q + 8'd1 : q0_q;
  end

  logic          buf_q, has_prev_q, iframe_q, pending_q;
  logic [PW-1:0] load_cnt_q;
  logic [CW-1:0] cc_q, drain_pos_q, cc_base, cc_new;
  logic          changed, frame_end, last_i;

  logic [7:0]    fstore [2*MAX_PIXELS];
  logic          cmap   [MAX_PIXELS];
  logic [7:0]    rd_q;
  logic          map_q;
  logic [PW-1:0] rpos;
  logic [AW-1:0] raddr, waddr;

  always_comb begin
    rpos  = cmd_i.rd_drain ? PW'(drain_pos_q) : load_cnt_q;
    raddr = buf_q ? AW'(rpos) : AW'(rpos) + AW'(MAX_PIXELS);
    waddr = buf_q ? AW'(load_cnt_q) + AW'(MAX_PIXELS) : AW'(load_cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      fstore[waddr]    <= idx_q;
      cmap[load_cnt_q] <= changed;
    end
    rd_q  <= fstore[raddr];
    map_q <= cmap[PW'(drain_pos_q)];
  end

  always_comb begin
    changed   = has_prev_q && (rd_q != idx_q);
    cc_base   = (load_cnt_q == '0) ? '0 : cc_q;
    cc_new    = cc_base + CW'(changed);
    frame_end = ((CW+1)'(load_cnt_q) + (CW+1)'(1)) >= (CW+1)'(pixels);
    last_i    = ((CW+1)'(drain_pos_q) + (CW+1)'(1)) >= (CW+1)'(pixels);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= 1'b0;
      has_prev_q  <= 1'b0;
      iframe_q    <= 1'b0;
      pending_q   <= 1'b0;
      load_cnt_q  <= '0;
      cc_q        <= '0;
      drain_pos_q <= '0;
    end else if (cmd_i.commit) begin
      cc_q      <= cc_new;
      pending_q <= 1'b0;
      if (frame_end) begin
        iframe_q    <= !has_prev_q || ((CW+1)'({cc_new, 1'b0}) >= (CW+1)'(pixels));
        has_prev_q  <= 1'b1;
        buf_q       <= ~buf_q;
        pending_q   <= 1'b1;
        drain_pos_q <= '0;
        load_cnt_q  <= '0;
      end else begin
        load_cnt_q <= load_cnt_q + PW'(1);
      end
    end else if (cmd_i.pos_inc) begin
      drain_pos_q <= drain_pos_q + CW'(1);
    end else if (cmd_i.emit) begin
      unique case (cmd_i.emit_kind)
        EMIT_NONE: ;
        EMIT_END:  pending_q <= 1'b0;
        EMIT_IFR: begin
          if (last_i) pending_q <= 1'b0;
          else drain_pos_q <= drain_pos_q + CW'(1);
        end
        EMIT_PFR: begin
          cc_q <= cc_q - CW'(1);
          if (cc_q == CW'(1)) pending_q <= 1'b0;
          else drain_pos_q <= drain_pos_q + CW'(1);
        end
        default: ;
      endcase
    end
  end

  logic [KW-1:0] div_cnt_q;
  logic [DW-1:0] div_rem_q;
  logic [PW-1:0] div_quot_q;
  logic [DW:0]   div_r2;
  logic          div_bit;

  always_comb begin
    div_r2  = {div_rem_q, div_quot_q[PW-1]};
    div_bit = div_r2 >= {1'b0, w_eff};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= KW'(PW);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - KW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_quot_q <= PW'(drain_pos_q);
      div_rem_q  <= '0;
    end else if (div_cnt_q != '0) begin
      div_rem_q  <= div_bit ? DW'(div_r2 - {1'b0, w_eff}) : DW'(div_r2);
      div_quot_q <= PW'({div_quot_q, div_bit});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.emit_kind)
        EMIT_NONE, EMIT_END: begin
          out_idx_o    <= 8'd0;
          out_x_o      <= 7'd0;
          out_y_o      <= 7'd0;
          out_iframe_o <= 1'b0;
          out_last_o   <= (cmd_i.emit_kind == EMIT_END);
          out_empty_o  <= 1'b1;
        end
        EMIT_IFR, EMIT_PFR: begin
          out_idx_o    <= rd_q;
          out_x_o      <= 7'(div_rem_q);
          out_y_o      <= 7'(div_quot_q);
          out_iframe_o <= (cmd_i.emit_kind == EMIT_IFR);
          out_last_o   <= (cmd_i.emit_kind == EMIT_IFR) ? last_i : (cc_q == CW'(1));
          out_empty_o  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.pending  = pending_q;
    stat_o.iframe   = iframe_q;
    stat_o.cnt_zero = (cc_q == '0);
    stat_o.scan_end = (drain_pos_q >= pixels);
    stat_o.map_hit  = map_q;
    stat_o.div_done = (div_cnt_q == '0);
    stat_o.out_free = !out_valid_o || out_ready_i;
  end

endmodule

// ===== sv/afde_ctrl.sv =====
// Controller: sequences loads, change scans, coordinate division and result beats.
module afde_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_drain_i,
  output logic            in_ready_o,
  input  afde_pkg::stat_t stat_i,
  output afde_pkg::cmd_t  cmd_o
);
  import afde_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_L1    = 4'd1;
  localparam logic [3:0] S_L2    = 4'd2;
  localparam logic [3:0] S_L3    = 4'd3;
  localparam logic [3:0] S_L4    = 4'd4;
  localparam logic [3:0] S_LCMT  = 4'd5;
  localparam logic [3:0] S_IDIV  = 4'd6;
  localparam logic [3:0] S_IEMIT = 4'd7;
  localparam logic [3:0] S_SRD   = 4'd8;
  localparam logic [3:0] S_SCHK  = 4'd9;
  localparam logic [3:0] S_PDIV  = 4'd10;
  localparam logic [3:0] S_PEMIT = 4'd11;
  localparam logic [3:0] S_PEND  = 4'd12;
  localparam logic [3:0] S_NONE  = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.cap       = 1'b0;
    cmd_o.commit    = 1'b0;
    cmd_o.rd_drain  = 1'b1;
    cmd_o.div_start = 1'b0;
    cmd_o.pos_inc   = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.emit_kind = EMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          priority if (!in_drain_i) begin
            state_d = S_L1;
          end else if (!stat_i.pending) begin
            state_d = S_NONE;
          end else if (stat_i.iframe) begin
            cmd_o.div_start = 1'b1;
            state_d = S_IDIV;
          end else if (stat_i.cnt_zero) begin
            state_d = S_PEND;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_L1: begin
        cmd_o.rd_drain = 1'b0;
        state_d = S_L2;
      end
      S_L2: begin
        cmd_o.rd_drain = 1'b0;
        state_d = S_L3;
      end
      S_L3: begin
        cmd_o.rd_drain = 1'b0;
        state_d = S_L4;
      end
      S_L4: begin
        cmd_o.rd_drain = 1'b0;
        state_d = S_LCMT;
      end
      S_LCMT: begin
        cmd_o.rd_drain = 1'b0;
        cmd_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      S_IDIV: begin
        if (stat_i.div_done) state_d = S_IEMIT;
      end
      S_IEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_kind = EMIT_IFR;
          state_d = S_IDLE;
        end
      end
      S_SRD: begin
        state_d = stat_i.scan_end ? S_PEND : S_SCHK;
      end
      S_SCHK: begin
        if (stat_i.map_hit) begin
          cmd_o.div_start = 1'b1;
          state_d = S_PDIV;
        end else begin
          cmd_o.pos_inc = 1'b1;
          state_d = S_SRD;
        end
      end
      S_PDIV: begin
        if (stat_i.div_done) state_d = S_PEMIT;
      end
      S_PEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_kind = EMIT_PFR;
          state_d = S_IDLE;
        end
      end
      S_PEND: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_kind = EMIT_END;
          state_d = S_IDLE;
        end
      end
      S_NONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_kind = EMIT_NONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/ascii_frame_delta_encoder_core.sv =====
// Top level of the ASCII frame delta encoder: register port, stream ports, controller and datapath.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata rgb pixel, s_tuser request kind
//   m_*      out  m_tvalid/m_tready  m_tdata index and position, m_tuser flags, m_tlast
//   apb      in   psel/penable       three registers at byte addresses 0, 4, 8
//
// A load runs through the four-stage index pipeline and then the store commit.
// A frame drain is paced by the bit-serial x/y divider; a delta drain adds a read and a
// check state per pixel scanned in the change map, the changed one included.
// Beats are taken one at a time.
// Reset clears all control state; store contents stay undefined until written.
// A result waiting in the output register stalls only the next beat that has a result.
module ascii_frame_delta_encoder_core #(
  parameter int MAX_PIXELS = 16384,
  parameter int MAX_DIM    = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red, green, blue
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // char_index, pos_x, pos_y, zero pad
  output logic [1:0]  m_tuser,   // is_iframe, empty_res
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import afde_pkg::*;

  logic [7:0] width_q, height_q;
  logic [8:0] levels_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd128;
      height_q <= 8'd128;
      levels_q <= 9'd256;
    end else if (wr_en) begin
      if (32'(paddr[3:2]) == REG_WIDTH)  width_q  <= pwdata[7:0];
      if (32'(paddr[3:2]) == REG_HEIGHT) height_q <= pwdata[7:0];
      if (32'(paddr[3:2]) == REG_LEVELS) levels_q <= pwdata[8:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (32'(paddr[3:2]) == REG_WIDTH)  prdata = 32'(width_q);
    if (32'(paddr[3:2]) == REG_HEIGHT) prdata = 32'(height_q);
    if (32'(paddr[3:2]) == REG_LEVELS) prdata = 32'(levels_q);
  end

  cmd_t  cmd;
  stat_t stat;
  logic [7:0] out_idx;
  logic [6:0] out_x, out_y;
  logic       out_iframe, out_empty;

  afde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_drain_i (s_tuser),
    .in_ready_o (s_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  afde_dp #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .width_i      (width_q),
    .height_i     (height_q),
    .levels_i     (levels_q),
    .red_i        (s_tdata[7:0]),
    .green_i      (s_tdata[15:8]),
    .blue_i       (s_tdata[23:16]),
    .out_ready_i  (m_tready),
    .out_valid_o  (m_tvalid),
    .out_idx_o    (out_idx),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_iframe_o (out_iframe),
    .out_last_o   (m_tlast),
    .out_empty_o  (out_empty)
  );

  assign m_tdata = {2'b00, out_y, out_x, out_idx};
  assign m_tuser = {out_empty, out_iframe};

`ifndef SYNTHESIS
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted twice in a row");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == 24'd0))
    else $error("empty result carries data");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result raised without an item in work");
`endif

endmodule
